// ----- hw/rtl/scsa_pkg.sv -----
// ============================================================================
// scsa_pkg
// Shared widths, constants, codes and controller/datapath interface types
// for the size-class slot allocator.
// ============================================================================
`default_nettype none

package scsa_pkg;

  localparam int NUM_CLASSES = 3;
  localparam int OP_W        = 2;
  localparam int CLASS_W     = 2;
  localparam int SLOT_W      = 4;
  localparam int STAMP_W     = 14;
  localparam int KIND_W      = 3;
  localparam int COUNT_W     = 5;
  localparam int CFG_W       = 48;
  localparam int IN_TIME_W   = 48;

  localparam int DEF_SLOTS_PER_CLASS = 16;
  localparam int DEF_TIME_WIDTH      = 48;

  localparam logic [STAMP_W:0]   STAMP_MOD    = 15'd10000;
  localparam logic [CFG_W-1:0]   EXPIRY_RESET = 48'd259200000;

  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_SWEEP   = 2'd2;

  localparam logic [KIND_W-1:0] KIND_GRANTED   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NONE_FREE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RELEASED  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_INVALID   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EXPIRED   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_NOTHING   = 3'd5;

  typedef struct packed {
    logic load;
    logic alloc_pop;
    logic alloc_commit;
    logic alloc_none;
    logic rel_read;
    logic rel_commit;
    logic rel_invalid;
    logic sw_issue;
    logic sw_check;
    logic sw_finish;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            alloc_avail;
    logic            rel_fmt_ok;
    logic            stamp_done;
    logic            chk_last;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/scsa_stamp.sv -----
// ============================================================================
// scsa_stamp
// Multi-cycle remainder unit: computes a time value modulo 10000 by folding
// it in 16-bit slices, most significant first, with a reciprocal multiply.
// ============================================================================
`default_nettype none

module scsa_stamp import scsa_pkg::*; #(
  parameter int TIME_WIDTH = DEF_TIME_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [TIME_WIDTH-1:0] value,
  output logic                  done,
  output logic [STAMP_W-1:0]    stamp
);

  localparam int NCH       = (TIME_WIDTH + 15) / 16;
  localparam int PAD_W     = NCH * 16;
  localparam int CNT_W     = $clog2(NCH + 1);
  localparam int ACC_W     = 26;
  localparam int RCP_W     = 27;
  localparam int PROD_W    = ACC_W + RCP_W;
  localparam int RCP_SHIFT = 40;
  localparam int QUO_W     = PROD_W - RCP_SHIFT;

  // Weight of the running remainder when the next slice is shifted in.
  localparam logic [STAMP_W-1:0] SLICE_FOLD = 14'd5536;
  // Rounded-up reciprocal of 10000 at 2^40, exact for every accumulator value.
  localparam logic [RCP_W-1:0]   RCP        = 27'd109951163;

  localparam logic [1:0] PH_ADD  = 2'd0;
  localparam logic [1:0] PH_RCP  = 2'd1;
  localparam logic [1:0] PH_SUB  = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  logic [PAD_W-1:0]   sh_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               run_r;
  logic [1:0]         phase_r;
  logic [ACC_W-1:0]   acc_r;
  logic [QUO_W-1:0]   quo_r;
  logic [STAMP_W-1:0] rem_r;
  logic [15:0]        slice;
  logic [ACC_W-1:0]   acc_nxt;
  logic [PROD_W-1:0]  prod;
  logic [ACC_W-1:0]   sub_nxt;

  assign slice   = sh_r[PAD_W-1 -: 16];
  assign acc_nxt = ACC_W'(rem_r) * ACC_W'(SLICE_FOLD) + ACC_W'(slice);
  assign prod    = PROD_W'(acc_r) * PROD_W'(RCP);
  assign sub_nxt = acc_r - ACC_W'(quo_r) * ACC_W'(STAMP_MOD);
  assign done    = run_r && (phase_r == PH_DONE);
  assign stamp   = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      phase_r <= PH_ADD;
      cnt_r   <= '0;
    end else if (start) begin
      run_r   <= 1'b1;
      phase_r <= PH_ADD;
      cnt_r   <= CNT_W'(NCH - 1);
    end else if (run_r) begin
      case (phase_r)
        PH_ADD: begin
          phase_r <= PH_RCP;
        end
        PH_RCP: begin
          phase_r <= PH_SUB;
        end
        PH_SUB: begin
          if (cnt_r == '0) begin
            phase_r <= PH_DONE;
          end else begin
            cnt_r   <= cnt_r - 1'b1;
            phase_r <= PH_ADD;
          end
        end
        PH_DONE: begin
          run_r <= 1'b0;
        end
        default: begin
          phase_r <= PH_ADD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= PAD_W'(value);
      rem_r <= '0;
    end else if (run_r) begin
      case (phase_r)
        PH_ADD: begin
          acc_r <= acc_nxt;
        end
        PH_RCP: begin
          quo_r <= prod[PROD_W-1:RCP_SHIFT];
        end
        PH_SUB: begin
          rem_r <= sub_nxt[STAMP_W-1:0];
          sh_r  <= sh_r << 16;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/scsa_dp.sv -----
// ============================================================================
// scsa_dp
// Datapath of the slot allocator: free-slot FIFOs, slot state memories,
// expiry compare, sweep scan counters and the result register.
// ============================================================================
`default_nettype none

module scsa_dp import scsa_pkg::*; #(
  parameter int SLOTS_PER_CLASS = DEF_SLOTS_PER_CLASS,
  parameter int TIME_WIDTH      = DEF_TIME_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  input  logic [OP_W-1:0]      in_operation,
  input  logic [CLASS_W-1:0]   in_size_class,
  input  logic [SLOT_W-1:0]    in_slot_index,
  input  logic [STAMP_W-1:0]   in_ticket_stamp,
  input  logic [IN_TIME_W-1:0] in_now_time,
  input  logic                 cfg_write_en,
  input  logic [CFG_W-1:0]     cfg_write_data,
  output logic                 out_strobe,
  output logic [KIND_W-1:0]    out_result_kind,
  output logic [CLASS_W-1:0]   out_granted_class,
  output logic [SLOT_W-1:0]    out_granted_slot,
  output logic [STAMP_W-1:0]   out_code_stamp,
  output logic                 out_last_result
);

  localparam int NS    = NUM_CLASSES * SLOTS_PER_CLASS;
  localparam int AW    = $clog2(NS);
  localparam int CMP_W = (TIME_WIDTH > IN_TIME_W) ? TIME_WIDTH : IN_TIME_W;
  localparam logic [SLOT_W-1:0]  LAST_SLOT  = SLOT_W'(SLOTS_PER_CLASS - 1);
  localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(SLOTS_PER_CLASS);
  localparam logic [CLASS_W-1:0] LAST_CLASS = CLASS_W'(NUM_CLASSES - 1);

  function automatic logic [AW-1:0] slot_addr(input logic [CLASS_W-1:0] c,
                                               input logic [SLOT_W-1:0] s);
    return AW'(c) * AW'(SLOTS_PER_CLASS) + AW'(s);
  endfunction

  // Latched request.
  logic [OP_W-1:0]       op_r;
  logic [CLASS_W-1:0]    cls_r;
  logic [SLOT_W-1:0]     slot_r;
  logic [STAMP_W-1:0]    tkt_r;
  logic [TIME_WIDTH-1:0] now_r;
  logic [CMP_W-1:0]      now_ext;
  logic [CFG_W-1:0]      expiry_r;

  // Free-slot FIFOs.
  logic [SLOT_W-1:0]  head_r  [NUM_CLASSES];
  logic [COUNT_W-1:0] count_r [NUM_CLASSES];
  logic [SLOT_W-1:0]  fifo_mem [NS];
  logic [NS-1:0]      fifo_vld_r;
  logic [SLOT_W-1:0]  fifo_rd_r;
  logic               fifo_rd_vld_r;
  logic [SLOT_W-1:0]  pos_r;
  logic [CLASS_W-1:0] acls_r;

  // Slot state.
  logic [NS-1:0]         active_r;
  logic [TIME_WIDTH-1:0] created_mem [NS];
  logic [STAMP_W-1:0]    stamp_mem [NS];
  logic [TIME_WIDTH-1:0] created_rd_r;
  logic [STAMP_W-1:0]    stamp_rd_r;

  // Sweep scan and pending result.
  logic [CLASS_W-1:0] iss_cls_r;
  logic [SLOT_W-1:0]  iss_slot_r;
  logic [CLASS_W-1:0] chk_cls_r;
  logic [SLOT_W-1:0]  chk_slot_r;
  logic               pend_vld_r;
  logic [CLASS_W-1:0] pend_cls_r;
  logic [SLOT_W-1:0]  pend_slot_r;
  logic [STAMP_W-1:0] pend_stamp_r;

  // Result register.
  logic               out_strobe_r;
  logic [KIND_W-1:0]  out_kind_r;
  logic [CLASS_W-1:0] out_cls_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic [STAMP_W-1:0] out_stamp_r;
  logic               out_last_r;

  logic               sel_found;
  logic [CLASS_W-1:0] sel_cls;
  logic [AW-1:0]      pop_addr;
  logic [SLOT_W-1:0]  alloc_slot;
  logic [AW-1:0]      commit_addr;
  logic               stamp_done;
  logic [STAMP_W-1:0] stamp_val;
  logic [AW-1:0]      rel_addr;
  logic               rel_ok;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      chk_addr;
  logic [CMP_W:0]     diff;
  logic               now_gt;
  logic               sw_hit;
  logic               push_en;
  logic [CLASS_W-1:0] push_cls;
  logic [SLOT_W-1:0]  push_slot;
  logic [COUNT_W:0]   tail_sum;
  logic [SLOT_W-1:0]  tail_pos;
  logic               push_room;
  logic               emit;
  logic [KIND_W-1:0]  emit_kind;
  logic [CLASS_W-1:0] emit_cls;
  logic [SLOT_W-1:0]  emit_slot;
  logic [STAMP_W-1:0] emit_stamp;
  logic               emit_last;

  assign now_ext = CMP_W'(in_now_time);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_operation;
      cls_r  <= in_size_class;
      slot_r <= in_slot_index;
      tkt_r  <= in_ticket_stamp;
      now_r  <= now_ext[TIME_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expiry_r <= EXPIRY_RESET;
    end else if (cfg_write_en) begin
      expiry_r <= cfg_write_data;
    end
  end

  // Allocation: first class at or above the requested one with a free slot.
  always_comb begin
    sel_found = 1'b0;
    sel_cls   = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (!sel_found && (CLASS_W'(c) >= cls_r) && (count_r[c] != '0)) begin
        sel_found = 1'b1;
        sel_cls   = CLASS_W'(c);
      end
    end
  end

  assign pop_addr    = slot_addr(sel_cls, head_r[sel_cls]);
  assign alloc_slot  = fifo_rd_vld_r ? fifo_rd_r : pos_r;
  assign commit_addr = slot_addr(acls_r, alloc_slot);

  scsa_stamp #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_stamp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.alloc_pop),
    .value (now_r),
    .done  (stamp_done),
    .stamp (stamp_val)
  );

  always_ff @(posedge clk) begin
    if (cmd.alloc_pop) begin
      fifo_rd_r     <= fifo_mem[pop_addr];
      fifo_rd_vld_r <= fifo_vld_r[pop_addr];
      pos_r         <= head_r[sel_cls];
      acls_r        <= sel_cls;
    end
  end

  // Release and sweep lookups share one read port on the slot memories.
  assign rel_addr = slot_addr(cls_r, slot_r);
  assign rd_addr  = cmd.rel_read ? rel_addr : slot_addr(iss_cls_r, iss_slot_r);
  assign chk_addr = slot_addr(chk_cls_r, chk_slot_r);
  assign rel_ok   = active_r[rel_addr] && (stamp_rd_r == tkt_r);

  always_ff @(posedge clk) begin
    if (cmd.rel_read || cmd.sw_issue) begin
      stamp_rd_r   <= stamp_mem[rd_addr];
      created_rd_r <= created_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc_commit) begin
      stamp_mem[commit_addr]   <= stamp_val;
      created_mem[commit_addr] <= now_r;
    end
  end

  assign diff   = {1'b0, CMP_W'(now_r)} - {1'b0, CMP_W'(created_rd_r)};
  assign now_gt = !diff[CMP_W] && (diff[CMP_W-1:0] != '0);
  assign sw_hit = active_r[chk_addr] && now_gt &&
                  (diff[CMP_W-1:0] > CMP_W'(expiry_r));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      iss_cls_r  <= '0;
      iss_slot_r <= '0;
    end else if (cmd.sw_issue) begin
      chk_cls_r  <= iss_cls_r;
      chk_slot_r <= iss_slot_r;
      if (iss_slot_r == LAST_SLOT) begin
        iss_slot_r <= '0;
        iss_cls_r  <= iss_cls_r + 1'b1;
      end else begin
        iss_slot_r <= iss_slot_r + 1'b1;
      end
    end
  end

  // Return of a slot to the tail of its class FIFO.
  always_comb begin
    push_en   = 1'b0;
    push_cls  = cls_r;
    push_slot = slot_r;
    if (cmd.rel_commit && rel_ok) begin
      push_en = 1'b1;
    end else if (cmd.sw_check && sw_hit) begin
      push_en   = 1'b1;
      push_cls  = chk_cls_r;
      push_slot = chk_slot_r;
    end
  end

  assign tail_sum  = (COUNT_W + 1)'(head_r[push_cls]) + (COUNT_W + 1)'(count_r[push_cls]);
  assign tail_pos  = (tail_sum >= (COUNT_W + 1)'(SLOTS_PER_CLASS)) ?
                     SLOT_W'(tail_sum - (COUNT_W + 1)'(SLOTS_PER_CLASS)) :
                     SLOT_W'(tail_sum);
  assign push_room = count_r[push_cls] < FULL_COUNT;

  always_ff @(posedge clk) begin
    if (push_en && push_room) begin
      fifo_mem[slot_addr(push_cls, tail_pos)] <= push_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fifo_vld_r <= '0;
      active_r   <= '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head_r[c]  <= '0;
        count_r[c] <= FULL_COUNT;
      end
    end else begin
      if (push_en && push_room) begin
        fifo_vld_r[slot_addr(push_cls, tail_pos)] <= 1'b1;
      end
      if (cmd.alloc_commit) begin
        active_r[commit_addr] <= 1'b1;
      end
      if (push_en) begin
        active_r[slot_addr(push_cls, push_slot)] <= 1'b0;
      end
      for (int c = 0; c < NUM_CLASSES; c++) begin
        if (cmd.alloc_pop && (sel_cls == CLASS_W'(c))) begin
          head_r[c]  <= (head_r[c] == LAST_SLOT) ? '0 : head_r[c] + 1'b1;
          count_r[c] <= count_r[c] - 1'b1;
        end else if (push_en && push_room && (push_cls == CLASS_W'(c))) begin
          count_r[c] <= count_r[c] + 1'b1;
        end
      end
    end
  end

  // A sweep holds each freed entry back one hit so the final one carries last.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
    end else if (cmd.load) begin
      pend_vld_r <= 1'b0;
    end else if (cmd.sw_check && sw_hit) begin
      pend_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sw_check && sw_hit) begin
      pend_cls_r   <= chk_cls_r;
      pend_slot_r  <= chk_slot_r;
      pend_stamp_r <= stamp_rd_r;
    end
  end

  always_comb begin
    emit       = 1'b0;
    emit_kind  = KIND_NONE_FREE;
    emit_cls   = '0;
    emit_slot  = '0;
    emit_stamp = '0;
    emit_last  = 1'b1;
    if (cmd.alloc_none) begin
      emit      = 1'b1;
      emit_kind = KIND_NONE_FREE;
    end else if (cmd.alloc_commit) begin
      emit       = 1'b1;
      emit_kind  = KIND_GRANTED;
      emit_cls   = acls_r;
      emit_slot  = alloc_slot;
      emit_stamp = stamp_val;
    end else if (cmd.rel_invalid) begin
      emit      = 1'b1;
      emit_kind = KIND_INVALID;
    end else if (cmd.rel_commit) begin
      emit = 1'b1;
      if (rel_ok) begin
        emit_kind  = KIND_RELEASED;
        emit_cls   = cls_r;
        emit_slot  = slot_r;
        emit_stamp = tkt_r;
      end else begin
        emit_kind = KIND_INVALID;
      end
    end else if (cmd.sw_check && sw_hit && pend_vld_r) begin
      emit       = 1'b1;
      emit_kind  = KIND_EXPIRED;
      emit_cls   = pend_cls_r;
      emit_slot  = pend_slot_r;
      emit_stamp = pend_stamp_r;
      emit_last  = 1'b0;
    end else if (cmd.sw_finish) begin
      emit = 1'b1;
      if (pend_vld_r) begin
        emit_kind  = KIND_EXPIRED;
        emit_cls   = pend_cls_r;
        emit_slot  = pend_slot_r;
        emit_stamp = pend_stamp_r;
      end else begin
        emit_kind = KIND_NOTHING;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r  <= emit_kind;
      out_cls_r   <= emit_cls;
      out_slot_r  <= emit_slot;
      out_stamp_r <= emit_stamp;
      out_last_r  <= emit_last;
    end
  end

  assign out_strobe        = out_strobe_r;
  assign out_result_kind   = out_kind_r;
  assign out_granted_class = out_cls_r;
  assign out_granted_slot  = out_slot_r;
  assign out_code_stamp    = out_stamp_r;
  assign out_last_result   = out_last_r;

  assign stat.op          = op_r;
  assign stat.alloc_avail = sel_found;
  assign stat.rel_fmt_ok  = (cls_r <= LAST_CLASS) && (COUNT_W'(slot_r) < FULL_COUNT);
  assign stat.stamp_done  = stamp_done;
  assign stat.chk_last    = (chk_cls_r == LAST_CLASS) && (chk_slot_r == LAST_SLOT);

endmodule

`default_nettype wire

// ----- hw/rtl/scsa_ctrl.sv -----
// ============================================================================
// scsa_ctrl
// Controller of the slot allocator: sequences allocate, release and sweep
// operations by issuing commands to the datapath.
// ============================================================================
`default_nettype none

module scsa_ctrl import scsa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DISPATCH = 3'd1;
  localparam logic [2:0] ST_A_WAIT   = 3'd2;
  localparam logic [2:0] ST_R_CHECK  = 3'd3;
  localparam logic [2:0] ST_S_RUN    = 3'd4;
  localparam logic [2:0] ST_S_END    = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (stat.op)
          OP_ALLOC: begin
            if (stat.alloc_avail) begin
              cmd.alloc_pop = 1'b1;
              state_nxt     = ST_A_WAIT;
            end else begin
              cmd.alloc_none = 1'b1;
              state_nxt      = ST_IDLE;
            end
          end
          OP_RELEASE: begin
            if (stat.rel_fmt_ok) begin
              cmd.rel_read = 1'b1;
              state_nxt    = ST_R_CHECK;
            end else begin
              cmd.rel_invalid = 1'b1;
              state_nxt       = ST_IDLE;
            end
          end
          OP_SWEEP: begin
            cmd.sw_issue = 1'b1;
            state_nxt    = ST_S_RUN;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_A_WAIT: begin
        if (stat.stamp_done) begin
          cmd.alloc_commit = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end
      ST_R_CHECK: begin
        cmd.rel_commit = 1'b1;
        state_nxt      = ST_IDLE;
      end
      ST_S_RUN: begin
        cmd.sw_check = 1'b1;
        if (stat.chk_last) begin
          state_nxt = ST_S_END;
        end else begin
          cmd.sw_issue = 1'b1;
        end
      end
      ST_S_END: begin
        cmd.sw_finish = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

`default_nettype wire

// ----- hw/rtl/size_class_slot_allocator_with_expiry.sv -----
// ============================================================================
// size_class_slot_allocator_with_expiry
// Three size classes of slots with free-slot FIFOs, ticket release and
// expiry sweep.
// ============================================================================
// A request is taken at a clock edge with start high and busy low; busy stays
// high until the request has issued all of its result beats. Operation 0
// allocates from the requested class or the next larger one with a free slot,
// 1 releases a slot by ticket, 2 frees every held slot older than the expiry
// limit, and 3 is dropped without a result.
// Each result beat is on the out_ ports for one cycle under out_strobe, and
// out_last_result marks the final beat of a request. The receiver has no way
// to stall the block; it must take every beat.
// An allocate waits for the modulo-10000 unit that forms the ticket stamp
// from the time, one 16-bit slice after another; with no free slot it
// answers from the dispatch state. A release with a class or slot index out
// of range is answered as invalid without a slot memory read. A sweep checks
// one slot per cycle through the slot memory read port. busy falls at the
// edge that registers the last beat.
// The expiry limit is written through cfg_write_en / cfg_write_data; the user
// must do so only while the block is idle, which the block does not enforce.
// Reset returns every FIFO to slots 0 up to SLOTS_PER_CLASS-1 in order, marks
// all slots free and loads the default expiry limit, and is ready out of reset.
// ============================================================================
`default_nettype none

module size_class_slot_allocator_with_expiry import scsa_pkg::*; #(
  parameter int SLOTS_PER_CLASS = DEF_SLOTS_PER_CLASS,
  parameter int TIME_WIDTH      = DEF_TIME_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [OP_W-1:0]      in_operation,
  input  logic [CLASS_W-1:0]   in_size_class,
  input  logic [SLOT_W-1:0]    in_slot_index,
  input  logic [STAMP_W-1:0]   in_ticket_stamp,
  input  logic [IN_TIME_W-1:0] in_now_time,
  input  logic                 cfg_write_en,
  input  logic [CFG_W-1:0]     cfg_write_data,
  output logic                 out_strobe,
  output logic [KIND_W-1:0]    out_result_kind,
  output logic [CLASS_W-1:0]   out_granted_class,
  output logic [SLOT_W-1:0]    out_granted_slot,
  output logic [STAMP_W-1:0]   out_code_stamp,
  output logic                 out_last_result
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  scsa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  scsa_dp #(
    .SLOTS_PER_CLASS (SLOTS_PER_CLASS),
    .TIME_WIDTH      (TIME_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_operation      (in_operation),
    .in_size_class     (in_size_class),
    .in_slot_index     (in_slot_index),
    .in_ticket_stamp   (in_ticket_stamp),
    .in_now_time       (in_now_time),
    .cfg_write_en      (cfg_write_en),
    .cfg_write_data    (cfg_write_data),
    .out_strobe        (out_strobe),
    .out_result_kind   (out_result_kind),
    .out_granted_class (out_granted_class),
    .out_granted_slot  (out_granted_slot),
    .out_code_stamp    (out_code_stamp),
    .out_last_result   (out_last_result)
  );

endmodule

`default_nettype wire
